### sv/assert_macros.svh
// assertion macros shared by the slice overlap metric modules
// expects signals named clock and reset in the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define SOM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication with the consequent in the next cycle
`define SOM_ASSERT_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

### sv/som_pkg.sv
// shared types and constants of the slice overlap metric block
// no dependencies
package som_pkg;

   localparam int VOXEL_W         = 16;
   localparam int VALUE_W         = 15;
   localparam int COUNT_W         = 17;
   localparam int NUM_W           = 18;
   localparam int DEN_W           = 19;
   localparam int SCALE_W         = 7;
   localparam int PERCENT_SCALE   = 100;
   localparam int COUNT_FIELD_MAX = 131071;
   localparam int VALUE_FIELD_MAX = 32767;

   localparam int SEL_W = 2;
   localparam logic [SEL_W-1:0] SEL_DICE = 2'd0;
   localparam logic [SEL_W-1:0] SEL_SENS = 2'd1;
   localparam logic [SEL_W-1:0] SEL_SPEC = 2'd2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] REG_MEASURE_SELECT = 1'b0;

   // one finished slice waiting for its division
   typedef struct packed {
      logic [NUM_W-1:0]   num;
      logic [DEN_W-1:0]   den;
      logic [COUNT_W-1:0] truth_pos;
      logic [COUNT_W-1:0] test_pos;
   } som_job_type;

endpackage

### sv/som_if.sv
// request and response channel interfaces of the slice overlap metric
// depends on som_pkg
interface som_req_if;
   import som_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [VOXEL_W-1:0]  truth_voxel;
   logic signed [VOXEL_W-1:0]  test_voxel;
   logic                       last_voxel;

   modport source (output valid, truth_voxel, test_voxel, last_voxel, input ready);
   modport sink   (input valid, truth_voxel, test_voxel, last_voxel, output ready);
endinterface

interface som_rsp_if;
   import som_pkg::*;

   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  measure_value;
   logic [COUNT_W-1:0]  truth_positives;
   logic [COUNT_W-1:0]  test_positives;

   modport source (output valid, measure_value, truth_positives, test_positives, input ready);
   modport sink   (input valid, measure_value, truth_positives, test_positives, output ready);
endinterface

### sv/som_front.sv
// front end: classifies voxel pairs, keeps the four slice counts and
// turns each slice end into a division job; depends on som_pkg, som_if
`include "assert_macros.svh"
module som_front #(
   parameter int MAX_SLICE_VOXELS = 65536
) (
   input  logic                        clock,
   input  logic                        reset,
   som_req_if.sink                     req_ch,
   input  logic [som_pkg::SEL_W-1:0]   measure_select,
   input  logic                        queue_full,
   output logic                        job_push,
   output som_pkg::som_job_type        job
);
   import som_pkg::*;

   localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(
      (MAX_SLICE_VOXELS > COUNT_FIELD_MAX) ? COUNT_FIELD_MAX : MAX_SLICE_VOXELS);

   logic [COUNT_W-1:0] tp_ff, fn_ff, fp_ff, tn_ff;
   logic [COUNT_W-1:0] tp_in, fn_in, fp_in, tn_in;
   logic [COUNT_W-1:0] tp_b, fn_b, fp_b, tn_b;
   logic [COUNT_W-1:0] snap_tp_ff, snap_fn_ff, snap_fp_ff, snap_tn_ff;
   logic [COUNT_W-1:0] snap_tp_in, snap_fn_in, snap_fp_in, snap_tn_in;
   logic               snap_valid_ff, snap_valid_in;
   logic               truth_pos, test_pos, accept, snap_move;
   logic [NUM_W-1:0]   sum_truth, sum_test;
   logic [NUM_W-1:0]   num;
   logic [DEN_W-1:0]   den;

   assign truth_pos = !req_ch.truth_voxel[VOXEL_W-1] && (req_ch.truth_voxel != '0);
   assign test_pos  = !req_ch.test_voxel[VOXEL_W-1] && (req_ch.test_voxel != '0);
   assign accept    = req_ch.valid && req_ch.ready;

   // counts including the current voxel, saturating
   always_comb begin
      tp_b = tp_ff;
      fn_b = fn_ff;
      fp_b = fp_ff;
      tn_b = tn_ff;
      priority if (truth_pos && test_pos) begin
         if (tp_ff < COUNT_LIMIT) tp_b = tp_ff + 1'b1;
      end else if (truth_pos) begin
         if (fn_ff < COUNT_LIMIT) fn_b = fn_ff + 1'b1;
      end else if (test_pos) begin
         if (fp_ff < COUNT_LIMIT) fp_b = fp_ff + 1'b1;
      end else begin
         if (tn_ff < COUNT_LIMIT) tn_b = tn_ff + 1'b1;
      end
   end

   // job from the slice snapshot
   always_comb begin
      sum_truth = NUM_W'(snap_tp_ff) + NUM_W'(snap_fn_ff);
      sum_test  = NUM_W'(snap_tp_ff) + NUM_W'(snap_fp_ff);
      unique case (measure_select)
         SEL_SENS: begin
            num = NUM_W'(snap_tp_ff);
            den = DEN_W'(sum_truth);
         end
         SEL_SPEC: begin
            num = NUM_W'(snap_tn_ff);
            den = DEN_W'(snap_tn_ff) + DEN_W'(snap_fp_ff);
         end
         default: begin
            num = {snap_tp_ff, 1'b0};
            den = DEN_W'(sum_truth) + DEN_W'(sum_test);
         end
      endcase
   end

   // empty denominator drops the slice without a queue slot
   assign snap_move = (den == '0) || !queue_full;
   assign job_push  = snap_valid_ff && (den != '0) && !queue_full;
   assign req_ch.ready = !snap_valid_ff || snap_move;

   always_comb begin
      job.num       = num;
      job.den       = den;
      job.truth_pos = (sum_truth > NUM_W'(COUNT_FIELD_MAX)) ?
                      COUNT_W'(COUNT_FIELD_MAX) : sum_truth[COUNT_W-1:0];
      job.test_pos  = (sum_test > NUM_W'(COUNT_FIELD_MAX)) ?
                      COUNT_W'(COUNT_FIELD_MAX) : sum_test[COUNT_W-1:0];
   end

   always_comb begin
      tp_in = tp_ff;
      fn_in = fn_ff;
      fp_in = fp_ff;
      tn_in = tn_ff;
      snap_tp_in = snap_tp_ff;
      snap_fn_in = snap_fn_ff;
      snap_fp_in = snap_fp_ff;
      snap_tn_in = snap_tn_ff;
      snap_valid_in = snap_valid_ff && !snap_move;
      if (accept) begin
         if (req_ch.last_voxel) begin
            tp_in = '0;
            fn_in = '0;
            fp_in = '0;
            tn_in = '0;
            snap_tp_in = tp_b;
            snap_fn_in = fn_b;
            snap_fp_in = fp_b;
            snap_tn_in = tn_b;
            snap_valid_in = 1'b1;
         end else begin
            tp_in = tp_b;
            fn_in = fn_b;
            fp_in = fp_b;
            tn_in = tn_b;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tp_ff <= '0;
         fn_ff <= '0;
         fp_ff <= '0;
         tn_ff <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         tp_ff <= tp_in;
         fn_ff <= fn_in;
         fp_ff <= fp_in;
         tn_ff <= tn_in;
         snap_valid_ff <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_tp_ff <= snap_tp_in;
      snap_fn_ff <= snap_fn_in;
      snap_fp_ff <= snap_fp_in;
      snap_tn_ff <= snap_tn_in;
   end

   `SOM_ASSERT(a_snap_not_lost, !(accept && snap_valid_ff && !snap_move), "pending slice overwritten")
   `SOM_ASSERT_NEXT(a_counts_clear, accept && req_ch.last_voxel, (tp_ff == '0) && (fn_ff == '0) && (fp_ff == '0) && (tn_ff == '0), "counts not cleared at slice end")
   `SOM_ASSERT(a_count_limit, (tp_ff <= COUNT_LIMIT) && (fn_ff <= COUNT_LIMIT) && (fp_ff <= COUNT_LIMIT) && (tn_ff <= COUNT_LIMIT), "count above limit")

endmodule

### sv/som_queue.sv
// two-entry job queue between the counting front and the divider
// depends on som_pkg
`include "assert_macros.svh"
module som_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  som_pkg::som_job_type  push_job,
   input  logic                  pop,
   output som_pkg::som_job_type  head_job,
   output logic                  not_empty,
   output logic                  full
);
   import som_pkg::*;

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   som_job_type        entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign head_job  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   `SOM_ASSERT(a_no_overflow, !(push && full), "push into full queue")
   `SOM_ASSERT(a_no_underflow, !(pop && !not_empty), "pop from empty queue")
   `SOM_ASSERT(a_count_range, count_ff <= CNT_W'(DEPTH), "queue count out of range")

endmodule

### sv/som_back.sv
// back end: restoring divider for the percent value and the response register
// depends on som_pkg, som_if
`include "assert_macros.svh"
module som_back #(
   parameter int FRACTION_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  som_pkg::som_job_type  head_job,
   input  logic                  job_ready,
   output logic                  job_pop,
   som_rsp_if.source             rsp_ch
);
   import som_pkg::*;

   // quotient never reaches 2^(7+FRACTION_BITS) since num <= den
   localparam int QW     = SCALE_W + FRACTION_BITS;
   localparam int CW     = $clog2(QW);
   localparam int PROD_W = NUM_W + SCALE_W;
   localparam int XW     = (QW > VALUE_W) ? QW : VALUE_W;
   localparam int VALUE_LIMIT = ((PERCENT_SCALE << FRACTION_BITS) > VALUE_FIELD_MAX) ?
                                VALUE_FIELD_MAX : (PERCENT_SCALE << FRACTION_BITS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CW-1:0]       step_ff, step_in;
   logic [DEN_W-1:0]    rem_ff, rem_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic [QW-1:0]       dq_ff, dq_in;
   logic [COUNT_W-1:0]  truth_pos_ff, truth_pos_in, test_pos_ff, test_pos_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic [COUNT_W-1:0]  out_truth_ff, out_truth_in, out_test_ff, out_test_in;
   logic [PROD_W-1:0]   prod;
   logic [DEN_W:0]      trial, diff;
   logic                ge, load_out;
   logic [XW-1:0]       quot_x;

   assign job_pop = (state_ff == ST_IDLE) && job_ready;
   assign prod    = PROD_W'(head_job.num) * PROD_W'(PERCENT_SCALE);

   assign trial = {rem_ff, dq_ff[QW-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = (trial >= {1'b0, den_ff});

   assign quot_x   = XW'(dq_ff);
   assign load_out = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      dq_in        = dq_ff;
      truth_pos_in = truth_pos_ff;
      test_pos_in  = test_pos_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_pop) begin
               rem_in       = DEN_W'(prod[PROD_W-1:SCALE_W]);
               dq_in        = QW'(prod[SCALE_W-1:0]) << FRACTION_BITS;
               den_in       = head_job.den;
               truth_pos_in = head_job.truth_pos;
               test_pos_in  = head_job.test_pos;
               step_in      = CW'(QW - 1);
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            dq_in  = {dq_ff[QW-2:0], ge};
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_DONE: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      value_in     = value_ff;
      out_truth_in = out_truth_ff;
      out_test_in  = out_test_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         value_in     = (quot_x > XW'(VALUE_FIELD_MAX)) ?
                        VALUE_W'(VALUE_FIELD_MAX) : quot_x[VALUE_W-1:0];
         out_truth_in = truth_pos_ff;
         out_test_in  = test_pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      rem_ff       <= rem_in;
      den_ff       <= den_in;
      dq_ff        <= dq_in;
      truth_pos_ff <= truth_pos_in;
      test_pos_ff  <= test_pos_in;
      value_ff     <= value_in;
      out_truth_ff <= out_truth_in;
      out_test_ff  <= out_test_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.measure_value   = value_ff;
   assign rsp_ch.truth_positives = out_truth_ff;
   assign rsp_ch.test_positives  = out_test_ff;

   `SOM_ASSERT(a_pop_when_idle, !job_pop || (state_ff == ST_IDLE), "job taken while dividing")
   `SOM_ASSERT(a_rem_below_den, (state_ff != ST_DIV) || (rem_ff < den_ff), "remainder not below divisor")
   `SOM_ASSERT(a_value_range, !rsp_valid_ff || (value_ff <= VALUE_W'(VALUE_LIMIT)), "measure above its bound")

endmodule

### sv/slice_overlap_metric.sv
// slice_overlap_metric top level: csr register, front, queue and divider
// depends on som_pkg, som_if, som_front, som_queue, som_back
//
// voxel pairs arrive on req_ch, one request per cycle when req_ch.ready is high;
// last_voxel marks the end of a slice. one response per slice leaves on rsp_ch
// with the dice, sensitivity or specificity percent (FRACTION_BITS fraction bits)
// and the truth and test positive counts. a slice with zero denominator gives
// no response.
// throughput: one voxel per cycle while req_ch.ready is high. a slice end
// passes the slice snapshot, the queue, the divider (idle, one-bit-per-cycle
// divide and done states) and the response register before rsp_ch.valid
// rises; the divider takes a new slice only after the last one is loaded out.
// a two-entry queue holds finished slices, so short slices back up into
// req_ch.ready only when slices end faster than the divider drains them.
// when rsp_ch.ready is low the response register holds, the divider waits,
// then the queue fills and finally req_ch.ready drops at the next slice end.
// reset clears the counts, the queue and the response register and sets
// measure_select to dice. measure_select is written on the csr port at
// address 0 and should only change while no slice is in flight.
module slice_overlap_metric #(
   parameter int MAX_SLICE_VOXELS = 65536,
   parameter int FRACTION_BITS    = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   som_req_if.sink                            req_ch,
   som_rsp_if.source                          rsp_ch,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [som_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [som_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [som_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import som_pkg::*;

   logic [SEL_W-1:0]      measure_select_ff, measure_select_in;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic                  csr_write;
   logic                  queue_full, queue_not_empty, job_push, job_pop;
   som_job_type           front_job, head_job;

   // csr port: zero wait states, only measure_select is implemented
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      measure_select_in = measure_select_ff;
      if (csr_write && (csr_index == REG_MEASURE_SELECT)) begin
         measure_select_in = csr_pwdata[SEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         measure_select_ff <= SEL_DICE;
      end else begin
         measure_select_ff <= measure_select_in;
      end
   end

   // readback of the selector, other addresses read zero
   assign csr_prdata = (csr_index == REG_MEASURE_SELECT) ?
                       CSR_DATA_W'(measure_select_ff) : '0;

   // counting front end, one voxel per cycle while req_ch.ready is high
   som_front #(
      .MAX_SLICE_VOXELS (MAX_SLICE_VOXELS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .measure_select (measure_select_ff),
      .queue_full     (queue_full),
      .job_push       (job_push),
      .job            (front_job)
   );

   // slice jobs waiting for the divider
   som_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_job  (front_job),
      .pop       (job_pop),
      .head_job  (head_job),
      .not_empty (queue_not_empty),
      .full      (queue_full)
   );

   // divider and response register
   som_back #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .job_ready (queue_not_empty),
      .job_pop   (job_pop),
      .rsp_ch    (rsp_ch)
   );

endmodule
